// ===== hw/rtl/sphere_point_from_uniform_pair_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sphere point picker
// Shared implication checks, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPHERE_POINT_FROM_UNIFORM_PAIR_TOP_ASSERT_SVH
`define SPHERE_POINT_FROM_UNIFORM_PAIR_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SPPICK_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sppick: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SPPICK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sppick: next-cycle check failed");

`endif

// ===== hw/rtl/sppick_pkg.sv =====
// ----------------------------------------------------------------------------
// sppick_pkg
// Widths, constants, the side-band payload type and the rounding helper of
// the sphere point picker.
// ----------------------------------------------------------------------------
package sppick_pkg;

  localparam int unsigned FRAC_BITS   = 15;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned OUT_W       = 16;
  localparam int unsigned IN_TDATA_W  = 2 * SAMPLE_W;
  localparam int unsigned OUT_TDATA_W = 3 * OUT_W;

  // Square of one sample, sum of two squares, square root radicand and root.
  localparam int unsigned SQ_W        = 2 * FRAC_BITS + 1;
  localparam int unsigned SUM_W       = SQ_W + 1;
  localparam int unsigned RAD_W       = 2 * FRAC_BITS + 2;
  localparam int unsigned ROOT_W      = FRAC_BITS + 1;
  localparam int unsigned REM_W       = ROOT_W + 2;
  localparam int unsigned SQRT_STAGES = RAD_W / 2;

  // Sample times root, and the doubled product that gets rounded.
  localparam int unsigned MUL_W       = SAMPLE_W + ROOT_W + 1;
  localparam int unsigned PROD_W      = MUL_W + 1;
  localparam int unsigned RND_W       = PROD_W - FRAC_BITS;

  localparam logic [SUM_W-1:0]         ONE2     = SUM_W'(1) << (2 * FRAC_BITS);
  localparam logic [ROOT_W-1:0]        ROOT_ONE = ROOT_W'(1) << FRAC_BITS;
  localparam logic [PROD_W-1:0]        HALF     = PROD_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0]  RND_HI   = RND_W'((2 ** (OUT_W - 1)) - 1);
  localparam logic signed [RND_W-1:0]  RND_LO   = RND_W'(-(2 ** (OUT_W - 1)));

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    logic signed [OUT_W-1:0]    z;
  } side_t;

  // Drops FRAC_BITS fraction bits, rounding to nearest with ties upward,
  // then saturates to the output range.
  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PROD_W-1:0] v);
    logic [PROD_W-1:0]        t;
    logic signed [RND_W-1:0]  sh;
    logic signed [OUT_W-1:0]  r;
    t  = v + HALF;
    sh = $signed(t[PROD_W-1:FRAC_BITS]);
    if (sh > RND_HI) begin
      r = RND_HI[OUT_W-1:0];
    end else if (sh < RND_LO) begin
      r = RND_LO[OUT_W-1:0];
    end else begin
      r = sh[OUT_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/sppick_isqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// sppick_isqrt_pipe
// Pipelined integer square root, one result bit per stage, carrying a
// side-band payload alongside. Each stage stalls only when it is full and
// the stage after it cannot take its contents.
// ----------------------------------------------------------------------------
`include "sphere_point_from_uniform_pair_top_assert.svh"

module sppick_isqrt_pipe
  import sppick_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [RAD_W-1:0]  rad_i,
  input  side_t             side_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [ROOT_W-1:0] root_o,
  output side_t             side_o
);

  logic [SQRT_STAGES-1:0] stg_v;
  logic [SQRT_STAGES:0]   stg_rdy;
  logic [RAD_W-1:0]       stg_rad  [SQRT_STAGES];
  logic [REM_W-1:0]       stg_rem  [SQRT_STAGES];
  logic [ROOT_W-1:0]      stg_root [SQRT_STAGES];
  side_t                  stg_side [SQRT_STAGES];

  assign stg_rdy[SQRT_STAGES] = ready_i;

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_step
    logic              pv;
    logic [RAD_W-1:0]  prad;
    logic [REM_W-1:0]  prem;
    logic [ROOT_W-1:0] proot;
    side_t             pside;
    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_d;
    logic [ROOT_W-1:0] root_d;
    logic              v_q;
    logic [RAD_W-1:0]  rad_q;
    logic [REM_W-1:0]  rem_q;
    logic [ROOT_W-1:0] root_q;
    side_t             side_q;

    if (j == 0) begin : g_first
      assign pv    = valid_i;
      assign prad  = rad_i;
      assign prem  = '0;
      assign proot = '0;
      assign pside = side_i;
    end else begin : g_next
      assign pv    = stg_v[j-1];
      assign prad  = stg_rad[j-1];
      assign prem  = stg_rem[j-1];
      assign proot = stg_root[j-1];
      assign pside = stg_side[j-1];
    end

    // Bring down the next two radicand bits and try root*4+1 against them.
    always_comb begin
      rem_sh = {prem[REM_W-3:0], prad[RAD_W-1 -: 2]};
      trial  = {proot, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {proot[ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {proot[ROOT_W-2:0], 1'b0};
      end
    end

    assign stg_rdy[j] = !v_q || stg_rdy[j+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (stg_rdy[j]) begin
        v_q <= pv;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stg_rdy[j] && pv) begin
        rad_q  <= prad << 2;
        rem_q  <= rem_d;
        root_q <= root_d;
        side_q <= pside;
      end
    end

    assign stg_v[j]    = v_q;
    assign stg_rad[j]  = rad_q;
    assign stg_rem[j]  = rem_q;
    assign stg_root[j] = root_q;
    assign stg_side[j] = side_q;
  end

  assign ready_o = stg_rdy[0];
  assign valid_o = stg_v[SQRT_STAGES-1];
  assign root_o  = stg_root[SQRT_STAGES-1];
  assign side_o  = stg_side[SQRT_STAGES-1];

  // The radicand never exceeds one, so neither does its root.
  `SPPICK_ASSERT_IMPL(a_root_max, valid_o, root_o <= ROOT_ONE)
  // Back-pressure reaches the input only when every stage is occupied.
  `SPPICK_ASSERT_IMPL(a_stall_full, !ready_o, (&stg_v) && !ready_i)
  // A stalled final stage keeps its root for the next cycle.
  `SPPICK_ASSERT_NEXT(a_root_hold, valid_o && !ready_i, valid_o && $stable(root_o))

endmodule

// ===== hw/rtl/sphere_point_from_uniform_pair_top.sv =====
// ----------------------------------------------------------------------------
// sphere_point_from_uniform_pair_top
// Sphere point picking from a uniform pair in Q1.15: a pair (a, b) with
// s = a^2 + b^2 < 1 becomes the unit vector (2a*sqrt(1-s), 2b*sqrt(1-s),
// 1-2s); pairs with s >= 1 are dropped without a result.
//
//   Channel  Dir  tdata fields (LSB first)              Meaning
//   s_axis   in   sample_a[15:0], sample_b[31:16]       uniform sample pair
//   m_axis   out  dir_x[15:0], dir_y[31:16], dir_z[47:32] unit vector
//
// One pair is accepted per cycle unless back-pressure fills the pipeline.
// A kept pair passes squares, sum, reject/radicand, 16 square root stages,
// products and rounding; the bit-per-stage root sets the pipeline depth.
// Reset clears only the valid bits; payload registers are not reset.
// Each stage holds while it is full and the next one cannot take it, so
// bubbles and dropped pairs are squeezed out and a stall loses nothing.
// ----------------------------------------------------------------------------
`include "sphere_point_from_uniform_pair_top_assert.svh"

module sphere_point_from_uniform_pair_top
  import sppick_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // sample_a, sample_b
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o    // dir_x, dir_y, dir_z
);

  logic signed [SAMPLE_W-1:0]   in_a;
  logic signed [SAMPLE_W-1:0]   in_b;
  logic signed [2*SAMPLE_W-1:0] sqa_full;
  logic signed [2*SAMPLE_W-1:0] sqb_full;

  logic                         s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy;
  logic                         s1_v_q, s2_v_q, s3_v_q, s4_v_q, m_v_q;

  logic signed [SAMPLE_W-1:0]   s1_a_q, s1_b_q;
  logic [SQ_W-1:0]              s1_sqa_q, s1_sqb_q;

  logic signed [SAMPLE_W-1:0]   s2_a_q, s2_b_q;
  logic [SUM_W-1:0]             s2_sum_d, s2_sum_q;

  logic                         s2_reject;
  logic signed [PROD_W-1:0]     z_wide;
  logic [RAD_W-1:0]             s3_rad_d, s3_rad_q;
  side_t                        s3_side_d, s3_side_q;

  logic                         sq_rdy, sq_v;
  logic [ROOT_W-1:0]            sq_root;
  side_t                        sq_side;

  logic signed [MUL_W-1:0]      s4_px_d, s4_py_d, s4_px_q, s4_py_q;
  logic signed [OUT_W-1:0]      s4_z_q;

  logic [OUT_TDATA_W-1:0]       m_data_d, m_data_q;

  assign in_a = $signed(s_axis_tdata_i[SAMPLE_W-1:0]);
  assign in_b = $signed(s_axis_tdata_i[IN_TDATA_W-1:SAMPLE_W]);

  // Ready chain: a stage loads when it is empty or its content moves on.
  assign s5_rdy = !m_v_q  || m_axis_tready_i;
  assign s4_rdy = !s4_v_q || s5_rdy;
  assign s3_rdy = !s3_v_q || sq_rdy;
  assign s2_rdy = !s2_v_q || s3_rdy;
  assign s1_rdy = !s1_v_q || s2_rdy;
  assign s_axis_tready_o = s1_rdy;

  // Stage 1: squares.
  assign sqa_full = in_a * in_a;
  assign sqb_full = in_b * in_b;

  // Stage 2: sum of squares.
  assign s2_sum_d = SUM_W'(s1_sqa_q) + SUM_W'(s1_sqb_q);

  // Stage 3: rejection, radicand 1-s and z = 1-2s.
  assign s2_reject = s2_sum_q >= ONE2;
  assign s3_rad_d  = RAD_W'(ONE2 - s2_sum_q);
  assign z_wide    = $signed(PROD_W'(ONE2) - (PROD_W'(s2_sum_q) << 1));

  always_comb begin
    s3_side_d.a = s2_a_q;
    s3_side_d.b = s2_b_q;
    s3_side_d.z = round_sat(z_wide);
  end

  sppick_isqrt_pipe u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s3_v_q),
    .ready_o (sq_rdy),
    .rad_i   (s3_rad_q),
    .side_i  (s3_side_q),
    .valid_o (sq_v),
    .ready_i (s4_rdy),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Stage 4: sample times root; the factor two is folded into rounding.
  assign s4_px_d = sq_side.a * $signed({1'b0, sq_root});
  assign s4_py_d = sq_side.b * $signed({1'b0, sq_root});

  // Stage 5: round, saturate and pack.
  assign m_data_d = {s4_z_q,
                     round_sat($signed({s4_py_q, 1'b0})),
                     round_sat($signed({s4_px_q, 1'b0}))};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      m_v_q  <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= s_axis_tvalid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q && !s2_reject;
      end
      if (s4_rdy) begin
        s4_v_q <= sq_v;
      end
      if (s5_rdy) begin
        m_v_q <= s4_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && s_axis_tvalid_i) begin
      s1_a_q   <= in_a;
      s1_b_q   <= in_b;
      s1_sqa_q <= sqa_full[SQ_W-1:0];
      s1_sqb_q <= sqb_full[SQ_W-1:0];
    end
    if (s2_rdy && s1_v_q) begin
      s2_a_q   <= s1_a_q;
      s2_b_q   <= s1_b_q;
      s2_sum_q <= s2_sum_d;
    end
    if (s3_rdy && s2_v_q) begin
      s3_rad_q  <= s3_rad_d;
      s3_side_q <= s3_side_d;
    end
    if (s4_rdy && sq_v) begin
      s4_px_q <= s4_px_d;
      s4_py_q <= s4_py_d;
      s4_z_q  <= sq_side.z;
    end
    if (s5_rdy && s4_v_q) begin
      m_data_q <= m_data_d;
    end
  end

  assign m_axis_tvalid_o = m_v_q;
  assign m_axis_tdata_o  = m_data_q;

  // Only pairs inside the unit disk reach the square root.
  `SPPICK_ASSERT_IMPL(a_rad_range, s3_v_q, (s3_rad_q != '0) && (s3_rad_q <= RAD_W'(ONE2)))
  // A pair on or outside the unit circle never enters the root pipeline.
  `SPPICK_ASSERT_NEXT(a_drop_reject, s2_v_q && s3_rdy && s2_reject, !s3_v_q)
  // The input is held off only when every stage up to the output is full.
  `SPPICK_ASSERT_IMPL(a_in_stall, !s_axis_tready_o,
                      s1_v_q && s2_v_q && s3_v_q && s4_v_q && m_v_q && !m_axis_tready_i)

endmodule

// ===== tb/sphere_point_from_uniform_pair_top_tb.sv =====
// ----------------------------------------------------------------------------
// sphere_point_from_uniform_pair_top_tb
// Streams uniform sample pairs into the sphere point picker and checks every
// unit vector that comes out against a fixed-point prediction. Pairs outside
// the unit disc must give no vector. Both stream sides idle at random, the
// receiver once stalls long enough to back up the pipeline, and the sender
// twice waits for the pipeline to drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_point_from_uniform_pair_top_tb;
  import sppick_pkg::*;

  localparam int          N_RANDOM    = 1500;
  localparam int          QUIET_ITEMS = 150;
  localparam int          LONG_HOLD   = 150;
  localparam longint      UNIT_SQ     = longint'(1) << (2 * FRAC_BITS);

  typedef struct {
    logic signed [SAMPLE_W-1:0] a;
    logic signed [SAMPLE_W-1:0] b;
    bit                         drain_first;
  } pair_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] z;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] x;
  } vec_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i = '0;   // sample_a, sample_b
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;        // dir_x, dir_y, dir_z

  pair_t  pending_pairs[$];
  vec_t   expected_vecs[$];
  int     errors = 0;
  int     vecs_seen = 0;
  longint cycle_cnt = 0;
  bit     pair_accepted = 1'b0;
  int     src_gap = 0;
  int     sink_stall = 0;
  bit     long_hold_done = 1'b0;

  sphere_point_from_uniform_pair_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Floor of the square root, one result bit at a time from the top.
  function automatic longint floor_sqrt(input longint n);
    longint r;
    longint t;
    r = 0;
    for (int k = FRAC_BITS; k >= 0; k--) begin
      t = r | (longint'(1) << k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // Nearest rounding with ties upward, then saturation to the output range.
  function automatic logic signed [OUT_W-1:0] round_q(input longint p);
    longint r;
    r = (p + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[OUT_W-1:0];
  endfunction

  // Returns 0 when the pair lies on or outside the unit circle.
  function automatic bit sphere_point(input logic signed [SAMPLE_W-1:0] a,
                                      input logic signed [SAMPLE_W-1:0] b,
                                      output vec_t v);
    longint sa;
    longint sb;
    longint rad_sq;
    longint root;
    sa = a;
    sb = b;
    v = '0;
    rad_sq = sa * sa + sb * sb;
    if (rad_sq >= UNIT_SQ) return 1'b0;
    root = floor_sqrt(UNIT_SQ - rad_sq);
    v.x = round_q(2 * sa * root);
    v.y = round_q(2 * sb * root);
    v.z = round_q(UNIT_SQ - 2 * rad_sq);
    return 1'b1;
  endfunction

  function automatic bit idle_allowed();
    return (pending_pairs.size() >= QUIET_ITEMS) && ((cycle_cnt / 256) % 3 != 0);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] clamp16(input longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SAMPLE_W-1:0];
  endfunction

  task automatic add_pair(input longint a, input longint b, input bit drain);
    pair_t p;
    p.a = clamp16(a);
    p.b = clamp16(b);
    p.drain_first = drain;
    pending_pairs.push_back(p);
  endtask

  // Sampling at the rising edge: check each vector transaction, then predict
  // from each pair transaction.
  always @(posedge clk_i) begin
    vec_t got;
    vec_t want;
    vec_t pred;
    cycle_cnt <= cycle_cnt + 1;
    pair_accepted = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o;
      vecs_seen <= vecs_seen + 1;
      if (expected_vecs.size() == 0) begin
        $error("unexpected vector x=%0d y=%0d z=%0d", got.x, got.y, got.z);
        errors++;
      end else begin
        want = expected_vecs.pop_front();
        if (got.x !== want.x) begin
          $error("dir_x: expected %0d, got %0d", want.x, got.x);
          errors++;
        end
        if (got.y !== want.y) begin
          $error("dir_y: expected %0d, got %0d", want.y, got.y);
          errors++;
        end
        if (got.z !== want.z) begin
          $error("dir_z: expected %0d, got %0d", want.z, got.z);
          errors++;
        end
      end
    end
    if (pair_accepted) begin
      if (sphere_point(s_axis_tdata_i[SAMPLE_W-1:0],
                       s_axis_tdata_i[2*SAMPLE_W-1:SAMPLE_W], pred)) begin
        expected_vecs.push_back(pred);
      end
    end
  end

  // Sender: a new pair goes out at the falling edge once the previous one
  // has been taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid_i || pair_accepted)) begin
      if (src_gap > 0) begin
        src_gap <= src_gap - 1;
        s_axis_tvalid_i <= 1'b0;
      end else if (pending_pairs.size() > 0 &&
                   !(pending_pairs[0].drain_first && expected_vecs.size() > 0)) begin
        s_axis_tdata_i <= {pending_pairs[0].b, pending_pairs[0].a};
        void'(pending_pairs.pop_front());
        s_axis_tvalid_i <= 1'b1;
        if (idle_allowed() && $urandom_range(0, 7) == 0) begin
          src_gap <= $urandom_range(1, 7);
        end
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // Receiver: short random stalls, and one long hold to back up the pipeline.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!long_hold_done && vecs_seen >= 400) begin
        long_hold_done <= 1'b1;
        sink_stall <= LONG_HOLD;
        m_axis_tready_i <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall <= sink_stall - 1;
        m_axis_tready_i <= 1'b0;
      end else if (idle_allowed() && $urandom_range(0, 7) == 0) begin
        sink_stall <= $urandom_range(0, 6);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin
    longint a;
    longint b;
    longint r;
    int     mode;

    // Directed pairs: origin, disc edge from both sides, extremes of the fields.
    add_pair(0, 0, 1'b0);
    add_pair(-32768, 0, 1'b0);
    add_pair(0, -32768, 1'b0);
    add_pair(-32768, -32768, 1'b0);
    add_pair(32767, 32767, 1'b0);
    add_pair(32767, 0, 1'b0);
    add_pair(0, 32767, 1'b0);
    add_pair(-32767, 0, 1'b0);
    add_pair(32767, 250, 1'b0);   // z rounds to minus one
    add_pair(-250, -32767, 1'b0);
    add_pair(23170, 0, 1'b0);
    add_pair(-23170, 0, 1'b0);
    add_pair(0, 23171, 1'b0);
    add_pair(23170, 23170, 1'b0);
    add_pair(23171, -23171, 1'b0);
    add_pair(1, 0, 1'b0);
    add_pair(0, -1, 1'b0);
    add_pair(-1, -1, 1'b0);
    add_pair(16384, 16384, 1'b0);
    add_pair(-16384, 28377, 1'b0);
    add_pair(26214, 19660, 1'b0);
    add_pair(26215, 19661, 1'b0);

    for (int i = 0; i < N_RANDOM; i++) begin
      mode = $urandom_range(0, 99);
      if (mode < 65) begin
        a = $signed(16'($urandom));
        b = $signed(16'($urandom));
      end else if (mode < 80) begin
        a = longint'($urandom_range(0, 1023)) - 512;
        b = longint'($urandom_range(0, 1023)) - 512;
      end else begin
        // Just inside or outside the unit circle.
        a = $signed(16'($urandom));
        r = floor_sqrt(UNIT_SQ - a * a);
        b = r + longint'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1) b = -b;
      end
      add_pair(a, b, i == 0 || i == 800);
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_pairs.size() > 0 || s_axis_tvalid_i) @(posedge clk_i);
    while (expected_vecs.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
